>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, status codes and constants shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int WORD_BITS    = 32;
   localparam int SIZE_W       = 13;
   localparam int BOFF_W       = 11;
   localparam int WOFF_W       = 9;
   localparam int USED_W       = 10;
   localparam int PROD_W       = 27;
   localparam int WORDS_W      = 24;
   localparam int NBLK_W       = 20;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [SIZE_W-1:0]    size_type;
   typedef logic [BOFF_W-1:0]    boff_type;
   typedef logic [WOFF_W-1:0]    woff_type;
   typedef logic [USED_W-1:0]    used_type;
   typedef logic [PROD_W-1:0]    prod_type;
   typedef logic [WORDS_W-1:0]   words_type;
   typedef logic [NBLK_W-1:0]    nblk_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOSPACE  = 2'd1,
      STATUS_MISALIGN = 2'd2,
      STATUS_RANGE    = 2'd3
   } status_type;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam word_type FULL_BLOCK = 32'hFFFF_FFFF;
   localparam used_type COUNT_MAX  = 10'd1023;

endpackage

`default_nettype wire

>>> sv/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Allocates and frees word regions in a pool of 32-word blocks tracked by a
// one-bit-per-word occupancy map held in a synchronous memory.
//
// The request channel (req_) carries a mode, a unit size, a unit count and,
// for a free, the byte offset of the region. The response channel (rsp_)
// returns a status, the word offset of an allocated region and the number of
// words in use after the operation. A transfer happens on a rising edge where
// valid is high and stall is low. One response follows every request.
//
// The block works on one request at a time. After the request transfer it
// passes through a size multiply state and a decoding state. An allocation
// then scans the map one block per memory read until it finds a fit or
// reaches the last block; a large allocation or free then writes one block
// per cycle. The memory port reads or writes one block per cycle.
// Synchronous reset clears the map and the used-word count at once. A
// response waiting under stall holds in the output register; the next request
// is still taken and its response waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_top #(
   parameter int BLOCKS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_mode,
   input  wire logic [bba_pkg::SIZE_W-1:0]  req_unit_size,
   input  wire logic [bba_pkg::SIZE_W-1:0]  req_unit_count,
   input  wire logic [bba_pkg::BOFF_W-1:0]  req_byte_offset,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [bba_pkg::WOFF_W-1:0]       rsp_word_offset,
   output logic [bba_pkg::USED_W-1:0]       rsp_used_words
);

   localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_W = $clog2(BLOCKS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DECODE,
      ST_SCAN,
      ST_FILL,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   function automatic logic [5:0] above_top(input bba_pkg::word_type v);
      logic [5:0] k;
      k = 6'd0;
      for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
         if (v[i]) begin
            k = 6'(i + 1);
         end
      end
      return k;
   endfunction

   function automatic bba_pkg::used_type sat_add(input bba_pkg::used_type c,
                                                 input logic [5:0] n);
      logic [bba_pkg::USED_W:0] s;
      s = {1'b0, c} + (bba_pkg::USED_W+1)'(n);
      return (s > (bba_pkg::USED_W+1)'(bba_pkg::COUNT_MAX)) ? bba_pkg::COUNT_MAX
                                                            : s[bba_pkg::USED_W-1:0];
   endfunction

   function automatic bba_pkg::used_type sat_sub(input bba_pkg::used_type c,
                                                 input logic [5:0] n);
      return (bba_pkg::USED_W'(n) >= c) ? '0 : bba_pkg::used_type'(c - bba_pkg::USED_W'(n));
   endfunction

   // Occupancy memory with per-entry valid bits; an unwritten entry reads as empty.
   bba_pkg::word_type mem_ff [BLOCKS];
   logic [BLOCKS-1:0] valid_ff;
   bba_pkg::word_type rd_data_ff;
   logic              rd_ok_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   bba_pkg::word_type wr_data;

   state_type            state_ff, state_in;
   logic                 mode_ff, mode_in;
   bba_pkg::size_type    usize_ff, usize_in;
   bba_pkg::size_type    ucount_ff, ucount_in;
   bba_pkg::boff_type    boff_ff, boff_in;
   bba_pkg::words_type   words_ff, words_in;
   logic [IDX_W-1:0]     chk_ff, chk_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [IDX_W-1:0]     fill_idx_ff, fill_idx_in;
   logic [CNT_W-1:0]     fill_left_ff, fill_left_in;
   bba_pkg::used_type    used_ff, used_in;
   bba_pkg::status_type  res_status_ff, res_status_in;
   bba_pkg::woff_type    res_woff_ff, res_woff_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bba_pkg::status_type  rsp_status_ff, rsp_status_in;
   bba_pkg::woff_type    rsp_woff_ff, rsp_woff_in;
   bba_pkg::used_type    rsp_used_ff, rsp_used_in;

   bba_pkg::word_type    data_word;
   bba_pkg::prod_type    prod;
   bba_pkg::nblk_type    nblk;
   logic [bba_pkg::NBLK_W:0] free_end;
   logic                 is_short;
   bba_pkg::word_type    small_mask;
   logic [5:0]           top_pos;
   logic [CNT_W-1:0]     run_next;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_ok_ff <= valid_ff[rd_addr];
      end
   end

   assign data_word  = rd_ok_ff ? rd_data_ff : '0;
   assign prod       = bba_pkg::PROD_W'(usize_ff) * bba_pkg::PROD_W'(ucount_ff);
   assign nblk       = bba_pkg::NBLK_W'((bba_pkg::PROD_W'(words_ff) + 27'd31) >> 5);
   assign free_end   = (bba_pkg::NBLK_W+1)'(boff_ff[10:7]) + (bba_pkg::NBLK_W+1)'(nblk);
   assign is_short   = (words_ff < 24'd32);
   assign small_mask = (32'h1 << words_ff[4:0]) - 32'h1;
   assign top_pos    = above_top(data_word);
   assign run_next   = (data_word == '0) ? CNT_W'(run_ff + 1'b1) : '0;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      usize_in      = usize_ff;
      ucount_in     = ucount_ff;
      boff_in       = boff_ff;
      words_in      = words_ff;
      chk_in        = chk_ff;
      run_in        = run_ff;
      fill_idx_in   = fill_idx_ff;
      fill_left_in  = fill_left_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_woff_in   = res_woff_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_woff_in   = rsp_woff_ff;
      rsp_used_in   = rsp_used_ff;
      rd_addr       = IDX_W'(chk_ff + 1'b1);
      wr_en         = 1'b0;
      wr_addr       = fill_idx_ff;
      wr_data       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               usize_in  = req_unit_size;
               ucount_in = req_unit_count;
               boff_in   = req_byte_offset;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            words_in = bba_pkg::WORDS_W'((prod + 27'd3) >> 2);
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            res_status_in = bba_pkg::STATUS_OK;
            res_woff_in   = '0;
            chk_in        = '0;
            run_in        = '0;
            rd_addr       = '0;
            if (mode_ff == bba_pkg::MODE_ALLOC) begin
               if (words_ff == '0) begin
                  res_status_in = bba_pkg::STATUS_NOSPACE;
                  state_in      = ST_DONE;
               end else if (!is_short && (nblk > bba_pkg::NBLK_W'(BLOCKS))) begin
                  res_status_in = bba_pkg::STATUS_NOSPACE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end else if (is_short) begin
               rd_addr     = IDX_W'(boff_ff[10:7]);
               fill_idx_in = IDX_W'(boff_ff[10:7]);
               if (boff_ff[1:0] != 2'b00) begin
                  res_status_in = bba_pkg::STATUS_MISALIGN;
                  state_in      = ST_DONE;
               end else if (32'(boff_ff[10:7]) >= 32'(BLOCKS)) begin
                  res_status_in = bba_pkg::STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_FREE_WR;
               end
            end else begin
               fill_idx_in  = IDX_W'(boff_ff[10:7]);
               fill_left_in = CNT_W'(nblk);
               if (boff_ff[6:0] != 7'd0) begin
                  res_status_in = bba_pkg::STATUS_MISALIGN;
                  state_in      = ST_DONE;
               end else if (free_end > (bba_pkg::NBLK_W+1)'(BLOCKS)) begin
                  res_status_in = bba_pkg::STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_SCAN: begin
            chk_in = IDX_W'(chk_ff + 1'b1);
            if (is_short) begin
               if ((data_word >> (6'd32 - words_ff[5:0])) == '0) begin
                  wr_en       = 1'b1;
                  wr_addr     = chk_ff;
                  wr_data     = data_word | (small_mask << top_pos[4:0]);
                  used_in     = sat_add(used_ff, words_ff[5:0]);
                  res_woff_in = bba_pkg::woff_type'({chk_ff, top_pos[4:0]});
                  state_in    = ST_DONE;
               end else if (chk_ff == IDX_W'(BLOCKS - 1)) begin
                  res_status_in = bba_pkg::STATUS_NOSPACE;
                  state_in      = ST_DONE;
               end
            end else begin
               run_in = run_next;
               if (bba_pkg::NBLK_W'(run_next) == nblk) begin
                  fill_idx_in  = IDX_W'(CNT_W'(chk_ff) + 1'b1 - CNT_W'(nblk));
                  fill_left_in = CNT_W'(nblk);
                  res_woff_in  = bba_pkg::woff_type'(
                     {IDX_W'(CNT_W'(chk_ff) + 1'b1 - CNT_W'(nblk)), 5'd0});
                  state_in     = ST_FILL;
               end else if (chk_ff == IDX_W'(BLOCKS - 1)) begin
                  res_status_in = bba_pkg::STATUS_NOSPACE;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (mode_ff == bba_pkg::MODE_ALLOC) begin
               wr_data = bba_pkg::FULL_BLOCK;
               used_in = sat_add(used_ff, 6'd32);
            end else begin
               wr_data = '0;
               used_in = sat_sub(used_ff, 6'd32);
            end
            fill_idx_in  = IDX_W'(fill_idx_ff + 1'b1);
            fill_left_in = CNT_W'(fill_left_ff - 1'b1);
            if (fill_left_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_FREE_WR: begin
            wr_en    = 1'b1;
            wr_data  = data_word & ~(small_mask << boff_ff[6:2]);
            used_in  = sat_sub(used_ff, words_ff[5:0]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_woff_in   = res_woff_ff;
               rsp_used_in   = used_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      usize_ff      <= usize_in;
      ucount_ff     <= ucount_in;
      boff_ff       <= boff_in;
      words_ff      <= words_in;
      chk_ff        <= chk_in;
      run_ff        <= run_in;
      fill_idx_ff   <= fill_idx_in;
      fill_left_ff  <= fill_left_in;
      res_status_ff <= res_status_in;
      res_woff_ff   <= res_woff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_woff_ff   <= rsp_woff_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_word_offset = rsp_woff_ff;
   assign rsp_used_words  = rsp_used_ff;

endmodule

`default_nettype wire

>>> dv/tb_bitmap_block_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Sends allocate and free requests through the valid/stall request channel
// and compares every response with a word-level model of the occupancy map
// and the used-word count. Directed requests cover the size and offset
// corners. Random traffic follows, mostly frees of live regions and fresh
// allocations, with some raw noise. Both channels idle in random bursts.
// ----------------------------------------------------------------------------

module tb_bitmap_block_allocator_top;

   localparam int BLOCKS       = 16;
   localparam int RANDOM_ITEMS = 650;
   localparam int CALM_FROM    = 550;
   localparam int DRAIN_CYCLES = 2 * BLOCKS + 8;

   typedef struct {
      bba_pkg::status_type status;
      bba_pkg::woff_type   woff;
      bba_pkg::used_type   used;
   } outcome_type;

   typedef struct {
      bba_pkg::boff_type boff;
      bba_pkg::size_type usize;
      bba_pkg::size_type ucount;
   } region_type;

   class alloc_scoreboard #(int POOL_BLOCKS = 16);
      bba_pkg::word_type occ_map [POOL_BLOCKS];
      int unsigned       used_count;
      outcome_type       pending [$];
      int                errors;

      function int unsigned above_top(bba_pkg::word_type v);
         for (int k = 32; k > 0; k--) begin
            if (v[k-1]) return k;
         end
         return 0;
      endfunction

      function void count_add(int unsigned n);
         int unsigned s;
         s = used_count + n;
         used_count = (s > bba_pkg::COUNT_MAX || s < used_count) ? bba_pkg::COUNT_MAX : s;
      endfunction

      function void count_sub(int unsigned n);
         used_count = (n >= used_count) ? 0 : used_count - n;
      endfunction

      function outcome_type note_request(logic mode, bba_pkg::size_type usize,
                                         bba_pkg::size_type ucount,
                                         bba_pkg::boff_type boff);
         int unsigned       words, nblk, run, first, limit, top, blk, pos;
         bba_pkg::word_type mask;
         bit                found;
         outcome_type       res;
         words = (32'(usize) * 32'(ucount) + 32'd3) >> 2;
         res.status = bba_pkg::STATUS_OK;
         res.woff = '0;
         found = 1'b0;
         if (mode == bba_pkg::MODE_ALLOC) begin
            if (words == 0) begin
               res.status = bba_pkg::STATUS_NOSPACE;
            end else if (words < 32) begin
               limit = 32'd1 << (32 - words);
               for (int b = 0; b < POOL_BLOCKS && !found; b++) begin
                  if (occ_map[b] < limit) begin
                     top = above_top(occ_map[b]);
                     mask = (32'd1 << words) - 32'd1;
                     mask = mask << top;
                     occ_map[b] |= mask;
                     count_add(words);
                     res.woff = bba_pkg::woff_type'(b * 32 + top);
                     found = 1'b1;
                  end
               end
               if (!found) res.status = bba_pkg::STATUS_NOSPACE;
            end else begin
               nblk = (words + 31) >> 5;
               run = 0;
               if (nblk <= POOL_BLOCKS) begin
                  for (int b = 0; b < POOL_BLOCKS && !found; b++) begin
                     run = (occ_map[b] == '0) ? run + 1 : 0;
                     if (run == nblk) begin
                        first = b + 1 - nblk;
                        for (int k = first; k <= b; k++) begin
                           occ_map[k] = bba_pkg::FULL_BLOCK;
                           count_add(32);
                        end
                        res.woff = bba_pkg::woff_type'(first * 32);
                        found = 1'b1;
                     end
                  end
               end
               if (!found) res.status = bba_pkg::STATUS_NOSPACE;
            end
         end else begin
            if (words < 32) begin
               blk = 32'(boff) >> 7;
               pos = (32'(boff) >> 2) & 31;
               if (boff[1:0] != 2'b00) begin
                  res.status = bba_pkg::STATUS_MISALIGN;
               end else if (blk >= POOL_BLOCKS) begin
                  res.status = bba_pkg::STATUS_RANGE;
               end else begin
                  mask = (32'd1 << words) - 32'd1;
                  mask = mask << pos;
                  occ_map[blk] &= ~mask;
                  count_sub(words);
               end
            end else begin
               nblk = (words + 31) >> 5;
               first = 32'(boff) >> 7;
               if (boff[6:0] != 7'd0) begin
                  res.status = bba_pkg::STATUS_MISALIGN;
               end else if (nblk > POOL_BLOCKS || first + nblk > POOL_BLOCKS) begin
                  res.status = bba_pkg::STATUS_RANGE;
               end else begin
                  for (int b = first; b < first + nblk; b++) begin
                     occ_map[b] = '0;
                     count_sub(32);
                  end
               end
            end
         end
         res.used = bba_pkg::used_type'(used_count);
         pending.push_back(res);
         return res;
      endfunction

      task report(string msg);
         if (errors < 40) $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [1:0] status, bba_pkg::woff_type woff,
                          bba_pkg::used_type used);
         outcome_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response, status %0d offset %0d used %0d",
                             status, woff, used));
            return;
         end
         want = pending.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
         if (woff !== want.woff)
            report($sformatf("word offset %0d, expected %0d", woff, want.woff));
         if (used !== want.used)
            report($sformatf("used words %0d, expected %0d", used, want.used));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_mode;
   bba_pkg::size_type req_unit_size;
   bba_pkg::size_type req_unit_count;
   bba_pkg::boff_type req_byte_offset;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   bba_pkg::woff_type rsp_word_offset;
   bba_pkg::used_type rsp_used_words;
   logic              bursts_on;

   alloc_scoreboard #(BLOCKS) sb = new;
   region_type live [$];

   always #2 clock = ~clock;

   bitmap_block_allocator_top #(.BLOCKS(BLOCKS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_unit_size   (req_unit_size),
      .req_unit_count  (req_unit_count),
      .req_byte_offset (req_byte_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_word_offset (rsp_word_offset),
      .rsp_used_words  (rsp_used_words)
   );

   task automatic send(logic mode, bba_pkg::size_type usize, bba_pkg::size_type ucount,
                       bba_pkg::boff_type boff, output outcome_type res);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_unit_size <= usize;
      req_unit_count <= ucount;
      req_byte_offset <= boff;
      do @(posedge clock); while (req_stall);
      res = sb.note_request(mode, usize, ucount, boff);
   endtask

   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_random_item();
      int                kind, idx;
      logic              mode;
      bba_pkg::size_type usize, ucount;
      bba_pkg::boff_type boff;
      outcome_type       res;
      kind = $urandom_range(0, 99);
      boff = '0;
      if (kind < 15) begin
         mode = 1'($urandom_range(0, 1));
         usize = bba_pkg::size_type'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                                : $urandom_range(0, 16));
         ucount = bba_pkg::size_type'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                                 : $urandom_range(0, 8));
         boff = bba_pkg::boff_type'($urandom_range(0, 2047));
      end else if (live.size() > 0 && (kind < 50 || live.size() > 24)) begin
         idx = $urandom_range(0, live.size() - 1);
         mode = bba_pkg::MODE_FREE;
         usize = live[idx].usize;
         ucount = live[idx].ucount;
         boff = live[idx].boff;
         live.delete(idx);
      end else if (kind < 60) begin
         mode = bba_pkg::MODE_ALLOC;
         usize = bba_pkg::size_type'($urandom_range(128, 1024));
         ucount = bba_pkg::size_type'($urandom_range(1, 2));
      end else begin
         mode = bba_pkg::MODE_ALLOC;
         usize = bba_pkg::size_type'($urandom_range(1, 16));
         ucount = bba_pkg::size_type'($urandom_range(1, 124 / usize));
      end
      send(mode, usize, ucount, boff, res);
      if (mode == bba_pkg::MODE_ALLOC && res.status == bba_pkg::STATUS_OK)
         live.push_back('{{res.woff, 2'b00}, usize, ucount});
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (bursts_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_word_offset, rsp_used_words);
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      outcome_type res;
      bit          gaps;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= bba_pkg::MODE_ALLOC;
      req_unit_size <= '0;
      req_unit_count <= '0;
      req_byte_offset <= '0;
      bursts_on <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send(bba_pkg::MODE_ALLOC, 13'd8191, 13'd0, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd4, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd3, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd4, 13'd31, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd128, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd8191, 13'd8191, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd4096, 13'd4096, 11'd0, res);
      send(bba_pkg::MODE_FREE, 13'd4, 13'd1, 11'd1, res);
      send(bba_pkg::MODE_FREE, 13'd4, 13'd4, 11'd248, res);
      send(bba_pkg::MODE_FREE, 13'd128, 13'd1, 11'd4, res);
      send(bba_pkg::MODE_FREE, 13'd128, 13'd2, 11'd1920, res);
      send(bba_pkg::MODE_FREE, 13'd128, 13'd1, 11'd1920, res);
      send(bba_pkg::MODE_FREE, 13'd0, 13'd0, 11'd0, res);
      send(bba_pkg::MODE_FREE, 13'd0, 13'd8191, 11'd2047, res);
      send(bba_pkg::MODE_FREE, 13'd4096, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_FREE, 13'd2048, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_FREE, 13'd4, 13'd8, 11'd64, res);
      send(bba_pkg::MODE_ALLOC, 13'd1, 13'd4, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd1920, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd2, 13'd2, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd128, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_ALLOC, 13'd124, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_FREE, 13'd2048, 13'd1, 11'd0, res);
      send(bba_pkg::MODE_FREE, 13'd4, 13'd1, 11'd2044, res);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gaps = (i < CALM_FROM) && ((i / 50) % 4 != 3);
         bursts_on <= gaps;
         if (gaps && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 15));
         send_random_item();
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
